[rtl/sswg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sswg_pkg
// shared types, register map and sine table generator for the waveform block
// ----------------------------------------------------------------------------
package sswg_pkg;

  // register map of the configuration port
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [CfgIndexW-1:0] REG_WAVE_KIND    = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_DC_OFFSET    = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_AMPLITUDE    = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_SAMPLE_COUNT = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_PHASE_STEP   = 3'd4;

  // waveform codes, the unused code behaves as dc only
  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_SQUARE = 2'd1;
  localparam logic [1:0] WAVE_DC     = 2'd2;

  localparam int unsigned SampleCountW = 9;
  localparam int unsigned SampleW      = 16;
  localparam int unsigned SineW        = 17;

  // pi/2 in q30
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  // per-sample control produced by the sequencer
  typedef struct packed {
    logic last;
    logic first_half;
  } seq_flags_t;

  // sin(x) in q15 from x in q30, taylor series up to x^15, elaboration only
  function automatic logic [15:0] sine_q15(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        q;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = '0;
    end
    q = ($unsigned(sum) + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[15:0];
  endfunction

endpackage

[rtl/sswg_sine_rom.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sswg_sine_rom
// quarter-wave sine table with quadrant folding, phase in, signed q1.15 out
// ----------------------------------------------------------------------------
module sswg_sine_rom #(
  parameter int unsigned PHASE_BITS     = 16,
  parameter int unsigned SINE_ROM_DEPTH = 256
) (
  input  logic [PHASE_BITS-1:0]              phase_i,
  output logic signed [sswg_pkg::SineW-1:0]  sine_o
);

  localparam int unsigned AddrW = $clog2(SINE_ROM_DEPTH + 1);
  localparam int unsigned FracW = PHASE_BITS - 2;
  localparam int unsigned ProdW = FracW + AddrW;

  logic [15:0]      rom_tbl [SINE_ROM_DEPTH+1];
  logic [1:0]       quad;
  logic [ProdW-1:0] scaled;
  logic [AddrW-1:0] addr_lin;
  logic [AddrW-1:0] addr;
  logic [15:0]      mag;

  // table built at elaboration, entry k = sin(pi/2 * k / depth)
  for (genvar k = 0; k <= SINE_ROM_DEPTH; k++) begin : g_rom
    localparam logic [63:0] XK =
      (sswg_pkg::PI_HALF_Q30 * 64'(k)) / 64'(SINE_ROM_DEPTH);
    assign rom_tbl[k] = sswg_pkg::sine_q15(XK);
  end

  assign quad     = phase_i[PHASE_BITS-1:PHASE_BITS-2];
  assign scaled   = ProdW'(phase_i[FracW-1:0]) * ProdW'(SINE_ROM_DEPTH);
  assign addr_lin = scaled[ProdW-1:FracW];
  // odd quadrants run the table backwards
  assign addr     = quad[0] ? (AddrW'(SINE_ROM_DEPTH) - addr_lin) : addr_lin;
  assign mag      = rom_tbl[addr];

  always_comb begin
    if (quad[1]) begin
      sine_o = -$signed({1'b0, mag});
    end else begin
      sine_o = $signed({1'b0, mag});
    end
  end

endmodule

[rtl/sswg_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sswg_seq
// sample index and phase accumulator, with period wrap and restart
// ----------------------------------------------------------------------------
module sswg_seq #(
  parameter int unsigned MAX_SAMPLES = 256,
  parameter int unsigned PHASE_BITS  = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 advance_i,
  input  logic                                 restart_i,
  input  logic [sswg_pkg::SampleCountW-1:0]    sample_count_i,
  input  logic [15:0]                          phase_step_i,
  output logic [$clog2(MAX_SAMPLES)-1:0]       idx_o,
  output logic [PHASE_BITS-1:0]                phase_o,
  output sswg_pkg::seq_flags_t                 flags_o
);

  localparam int unsigned IdxW = $clog2(MAX_SAMPLES);
  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned CmpW =
    (CntW > sswg_pkg::SampleCountW) ? CntW : sswg_pkg::SampleCountW;

  logic [IdxW-1:0]       idx_q, idx_d;
  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [CmpW-1:0]       count_raw;
  logic [CntW-1:0]       count_eff;

  // clamp the count into 2 .. max samples
  always_comb begin
    count_raw = CmpW'(sample_count_i);
    if (count_raw < CmpW'(2)) begin
      count_eff = CntW'(2);
    end else if (count_raw > CmpW'(MAX_SAMPLES)) begin
      count_eff = CntW'(MAX_SAMPLES);
    end else begin
      count_eff = count_raw[CntW-1:0];
    end
  end

  assign idx_o   = restart_i ? '0 : idx_q;
  assign phase_o = restart_i ? '0 : phase_q;

  // last also covers an index left past a lowered count
  assign flags_o.last       = (CntW'(idx_o) + CntW'(1)) >= count_eff;
  assign flags_o.first_half = ((CntW+1)'({idx_o, 1'b0})) < (CntW+1)'(count_eff);

  always_comb begin
    if (flags_o.last) begin
      idx_d   = '0;
      phase_d = '0;
    end else begin
      idx_d   = idx_o + IdxW'(1);
      phase_d = phase_o + PHASE_BITS'(phase_step_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      phase_q <= '0;
    end else if (advance_i) begin
      idx_q   <= idx_d;
      phase_q <= phase_d;
    end
  end

endmodule

[rtl/sswg_shape.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sswg_shape
// scales the waveform, adds the dc level and saturates to q8.8
// ----------------------------------------------------------------------------
module sswg_shape (
  input  logic [1:0]                          wave_kind_i,
  input  logic signed [sswg_pkg::SampleW-1:0] dc_offset_i,
  input  logic signed [sswg_pkg::SampleW-1:0] amplitude_i,
  input  logic signed [sswg_pkg::SineW-1:0]   sine_i,
  input  logic                                first_half_i,
  output logic signed [sswg_pkg::SampleW-1:0] sample_o,
  output logic                                clipped_o
);

  logic signed [32:0] prod;
  logic signed [33:0] prod_rnd;
  logic signed [18:0] sine_term;
  logic signed [18:0] amp_ext;
  logic signed [18:0] term;
  logic signed [19:0] sum;

  assign prod      = amplitude_i * sine_i;
  // round half up, arithmetic shift floors
  assign prod_rnd  = 34'(prod) + 34'sd16384;
  assign sine_term = 19'(prod_rnd >>> 15);
  assign amp_ext   = 19'(amplitude_i);

  always_comb begin
    case (wave_kind_i)
      sswg_pkg::WAVE_SINE:   term = sine_term;
      sswg_pkg::WAVE_SQUARE: term = first_half_i ? -amp_ext : amp_ext;
      sswg_pkg::WAVE_DC:     term = '0;
      default:               term = '0;
    endcase
  end

  assign sum = 20'(dc_offset_i) + 20'(term);

  always_comb begin
    if (sum > 20'sd32767) begin
      sample_o  = 16'sh7fff;
      clipped_o = 1'b1;
    end else if (sum < -20'sd32768) begin
      sample_o  = -16'sh8000;
      clipped_o = 1'b1;
    end else begin
      sample_o  = sum[15:0];
      clipped_o = 1'b0;
    end
  end

endmodule

[rtl/sine_square_waveform_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_square_waveform_generator
// direct digital synthesis source: one sine, square or dc sample per tick
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_ready_o  restart_i
//   out      output     out_valid_o/out_ready_i  sample_o, position_o,
//                                                period_end_o, clipped_o
//   cfg      input      cfg_we_i                 cfg_index_i, cfg_data_i
//
// one transaction per clock sustained while the output is taken; each tick
// passes a table lookup stage, then a multiply and saturate stage
// the single amplitude multiply in the second stage sets the clock budget
// reset clears the index, the phase and both pipeline valids and loads the
// register defaults (sine, dc 0, amplitude 1.0, 128 samples, step 512)
// a stalled output backs up through both stages; in_ready_o drops only when
// both stages hold data and the output is not taken
// ----------------------------------------------------------------------------
module sine_square_waveform_generator #(
  parameter int unsigned MAX_SAMPLES    = 256,
  parameter int unsigned PHASE_BITS     = 16,
  parameter int unsigned SINE_ROM_DEPTH = 256
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration writes
  input  logic                                  cfg_we_i,
  input  logic [sswg_pkg::CfgIndexW-1:0]        cfg_index_i,
  input  logic [sswg_pkg::CfgDataW-1:0]         cfg_data_i,
  // tick channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  restart_i,
  // sample channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [sswg_pkg::SampleW-1:0]   sample_o,
  output logic [$clog2(MAX_SAMPLES)-1:0]        position_o,
  output logic                                  period_end_o,
  output logic                                  clipped_o
);

  localparam int unsigned IdxW = $clog2(MAX_SAMPLES);

  // configuration registers
  logic [1:0]                          wave_kind_q;
  logic [sswg_pkg::SampleW-1:0]        dc_offset_q;
  logic [sswg_pkg::SampleW-1:0]        amplitude_q;
  logic [sswg_pkg::SampleCountW-1:0]   sample_count_q;
  logic [15:0]                         phase_step_q;

  // handshake
  logic in_fire;
  logic out_fire;
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_adv;

  // sequencer outputs for the tick being offered
  logic [IdxW-1:0]                     seq_idx;
  logic [PHASE_BITS-1:0]               seq_phase;
  sswg_pkg::seq_flags_t                seq_flags;
  logic signed [sswg_pkg::SineW-1:0]   rom_sine;

  // lookup stage
  logic [IdxW-1:0]                     s1_idx_q;
  sswg_pkg::seq_flags_t                s1_flags_q;
  logic signed [sswg_pkg::SineW-1:0]   s1_sine_q;

  // output stage
  logic signed [sswg_pkg::SampleW-1:0] shape_sample;
  logic                                shape_clipped;
  logic signed [sswg_pkg::SampleW-1:0] sample_q;
  logic [IdxW-1:0]                     position_q;
  logic                                period_end_q;
  logic                                clipped_q;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_kind_q    <= sswg_pkg::WAVE_SINE;
      dc_offset_q    <= 16'd0;
      amplitude_q    <= 16'd256;
      sample_count_q <= 9'd128;
      phase_step_q   <= 16'd512;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sswg_pkg::REG_WAVE_KIND:    wave_kind_q    <= cfg_data_i[1:0];
        sswg_pkg::REG_DC_OFFSET:    dc_offset_q    <= cfg_data_i;
        sswg_pkg::REG_AMPLITUDE:    amplitude_q    <= cfg_data_i;
        sswg_pkg::REG_SAMPLE_COUNT: sample_count_q <= cfg_data_i[8:0];
        sswg_pkg::REG_PHASE_STEP:   phase_step_q   <= cfg_data_i;
        default: ;  // writes past the map are dropped
      endcase
    end
  end

  // -------------------------------------------------------------- handshake
  // output slot frees when empty or taken; lookup stage moves when it can
  assign out_fire    = out_valid_q && out_ready_i;
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // -------------------------------------------------------------- sequencer
  // index and phase advance on every accepted tick
  sswg_seq #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .PHASE_BITS  (PHASE_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (in_fire),
    .restart_i      (restart_i),
    .sample_count_i (sample_count_q),
    .phase_step_i   (phase_step_q),
    .idx_o          (seq_idx),
    .phase_o        (seq_phase),
    .flags_o        (seq_flags)
  );

  sswg_sine_rom #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ROM_DEPTH (SINE_ROM_DEPTH)
  ) u_sine_rom (
    .phase_i (seq_phase),
    .sine_o  (rom_sine)
  );

  // lookup stage register, loads on every accepted tick
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_idx_q   <= seq_idx;
      s1_flags_q <= seq_flags;
      s1_sine_q  <= rom_sine;
    end
  end

  // ----------------------------------------------------------- output stage
  // user keeps config stable while pipe holds data (unenforced), so read live
  sswg_shape u_shape (
    .wave_kind_i  (wave_kind_q),
    .dc_offset_i  ($signed(dc_offset_q)),
    .amplitude_i  ($signed(amplitude_q)),
    .sine_i       (s1_sine_q),
    .first_half_i (s1_flags_q.first_half),
    .sample_o     (shape_sample),
    .clipped_o    (shape_clipped)
  );

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      sample_q     <= shape_sample;
      position_q   <= s1_idx_q;
      period_end_q <= s1_flags_q.last;
      clipped_q    <= shape_clipped;
    end
  end

  assign sample_o     = sample_q;
  assign position_o   = position_q;
  assign period_end_o = period_end_q;
  assign clipped_o    = clipped_q;

  // ------------------------------------------------------------- assertions
  // a full pipe with a stalled output must refuse new ticks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("tick accepted while pipeline is blocked");

  // after the last sample of a period the index restarts at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && seq_flags.last) |=> (seq_idx == '0))
    else $error("index did not wrap after period end");

  // otherwise the index steps by one unless a restart is offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !seq_flags.last) |=>
      ((seq_idx == $past(seq_idx) + IdxW'(1)) || restart_i))
    else $error("index did not advance by one");

  // a clipped sample sits at one of the rails
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && clipped_o) |-> (sample_o == 16'h7fff || sample_o == 16'h8000))
    else $error("clipped sample is not at a rail");

endmodule

[dv/sine_square_waveform_generator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_square_waveform_generator_test
// self-checking bench for the waveform sample source: ticks are sent on the
// input channel, every sample is predicted from a local model of the index,
// phase accumulator and quarter-wave sine table, and compared field by field
// with what leaves the output channel; both channels idle and stall at random
// ----------------------------------------------------------------------------
module sine_square_waveform_generator_test;

  // block configuration, kept equal to the instance parameters
  localparam int unsigned MaxSamples = 256;
  localparam int unsigned PhaseBits  = 16;
  localparam int unsigned RomDepth   = 256;
  localparam int unsigned PosW       = $clog2(MaxSamples);

  // bench timing and run length
  localparam int unsigned HalfPeriod      = 4;
  localparam int unsigned ResetCycles     = 7;
  localparam int unsigned SettleCycles    = 6;
  localparam int unsigned CycleLimit      = 200000;
  localparam int unsigned RandomTicks     = 500;
  localparam int unsigned FullPeriodTicks = 300;
  localparam int unsigned ShownMismatches = 10;

  // pi/2 in q30, seeds the sine table
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  // codes not named by the package
  localparam logic [1:0]                     WaveUnused     = 2'd3;
  localparam logic [sswg_pkg::CfgIndexW-1:0] RegFirstUnused =
    sswg_pkg::REG_PHASE_STEP + 3'd1;
  localparam int unsigned                    RegTop         = 2**sswg_pkg::CfgIndexW - 1;

  typedef struct packed {
    logic signed [sswg_pkg::SampleW-1:0] sample;
    logic [PosW-1:0]                     position;
    logic                                period_end;
    logic                                clipped;
  } sample_rec_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  // dut ports, inputs known from time zero
  logic                                clk_i       = 1'b0;
  logic                                rst_ni      = 1'b0;
  logic                                cfg_we_i    = 1'b0;
  logic [sswg_pkg::CfgIndexW-1:0]      cfg_index_i = '0;
  logic [sswg_pkg::CfgDataW-1:0]       cfg_data_i  = '0;
  logic                                in_valid_i  = 1'b0;
  logic                                in_ready_o;
  logic                                restart_i   = 1'b0;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  logic signed [sswg_pkg::SampleW-1:0] sample_o;
  logic [PosW-1:0]                     position_o;
  logic                                period_end_o;
  logic                                clipped_o;

  // shadow copy of the registers, at their reset values
  logic [1:0]                        kind_reg  = sswg_pkg::WAVE_SINE;
  logic [15:0]                       dc_reg    = 16'd0;
  logic [15:0]                       amp_reg   = 16'd256;
  logic [sswg_pkg::SampleCountW-1:0] cnt_reg   = 9'd128;
  logic [15:0]                       step_reg  = 16'd512;

  // predicted sequencer state
  logic [PosW-1:0]      idx_q   = '0;
  logic [PhaseBits-1:0] phase_q = '0;

  int sine_rom [RomDepth+1];

  // samples predicted for accepted ticks, oldest first
  sample_rec_t pending_samples [$];

  // idling mix, in percent of cycles
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // run statistics
  int unsigned mismatch_count  = 0;
  int unsigned tick_count      = 0;
  int unsigned restart_count   = 0;
  int unsigned checked_count   = 0;
  int unsigned clip_count      = 0;
  int unsigned end_count       = 0;
  int unsigned setup_count     = 0;
  int unsigned cycle_count     = 0;

  sine_square_waveform_generator #(
    .MAX_SAMPLES   (MaxSamples),
    .PHASE_BITS    (PhaseBits),
    .SINE_ROM_DEPTH(RomDepth)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_o    (sample_o),
    .position_o  (position_o),
    .period_end_o(period_end_o),
    .clipped_o   (clipped_o)
  );

  // 8 ns clock
  always begin
    #(HalfPeriod) clk_i = 1'b1;
    #(HalfPeriod) clk_i = 1'b0;
  end

  // receiver back-pressure, redrawn every cycle on the falling edge
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // sin(pi/2 * k / depth) in q15: q30 taylor series to x^15, rounded half up
  function automatic int rom_entry(int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned q;
    longint          sum;
    x    = (HalfPiQ30 * k) / RomDepth;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
      // odd powers alternate in sign
      if (n % 2) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    q = ($unsigned(sum) + 64'd16384) >> 15;
    return (q > 32767) ? 32767 : int'(q);
  endfunction

  // sample for one tick; advances the shadow index and phase
  function automatic sample_rec_t next_sample(input logic restart);
    int          count;
    int          dc;
    int          amp;
    int unsigned quad;
    int unsigned frac;
    int unsigned addr;
    int          sine;
    longint      v;
    logic        last;
    sample_rec_t r;
    // out-of-range counts are pinned to the legal span
    count = int'(cnt_reg);
    if (count < 2) begin
      count = 2;
    end
    if (count > MaxSamples) begin
      count = MaxSamples;
    end
    dc  = $signed(dc_reg);
    amp = $signed(amp_reg);
    if (restart) begin
      idx_q   = '0;
      phase_q = '0;
    end
    v = dc;
    case (kind_reg)
      sswg_pkg::WAVE_SINE: begin
        // top two phase bits pick the quadrant, the rest addresses the table
        quad = (int'(phase_q) >> (PhaseBits - 2)) & 3;
        frac = int'(phase_q) & ((1 << (PhaseBits - 2)) - 1);
        addr = (frac * RomDepth) >> (PhaseBits - 2);
        sine = sine_rom[(quad & 1) ? RomDepth - addr : addr];
        if (quad & 2) begin
          sine = -sine;
        end
        // product scaled back by 2^15, rounding half toward plus infinity
        v = v + ((longint'(amp) * sine + 16384) >>> 15);
      end
      sswg_pkg::WAVE_SQUARE: begin
        // amplitude subtracted in the first half, added in the second half
        v = (2 * int'(idx_q) < count) ? v - amp : v + amp;
      end
      default: begin
      end
    endcase
    r.clipped = 1'b0;
    if (v > 32767) begin
      v = 32767;
      r.clipped = 1'b1;
    end else if (v < -32768) begin
      v = -32768;
      r.clipped = 1'b1;
    end
    // an index left past the end by a lowered count also closes the period
    last         = (int'(idx_q) >= count - 1);
    r.sample     = v[sswg_pkg::SampleW-1:0];
    r.position   = idx_q;
    r.period_end = last;
    if (last) begin
      idx_q   = '0;
      phase_q = '0;
    end else begin
      idx_q   = idx_q + 1'b1;
      phase_q = phase_q + step_reg;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  function automatic void flag_mismatch(string what, longint want, longint got);
    mismatch_count++;
    if (mismatch_count <= ShownMismatches) begin
      $display("[%0t] %s: expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // one process sees both channels: the output transaction is checked first,
  // then a tick taken at the same edge is predicted and queued
  always @(posedge clk_i) begin : sample_monitor
    sample_rec_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        checked_count++;
        if (pending_samples.size() == 0) begin
          flag_mismatch("sample with no tick pending", 0, sample_o);
        end else begin
          want = pending_samples.pop_front();
          if (sample_o !== want.sample) begin
            flag_mismatch("sample", want.sample, sample_o);
          end
          if (position_o !== want.position) begin
            flag_mismatch("position", want.position, position_o);
          end
          if (period_end_o !== want.period_end) begin
            flag_mismatch("period_end", want.period_end, period_end_o);
          end
          if (clipped_o !== want.clipped) begin
            flag_mismatch("clipped", want.clipped, clipped_o);
          end
          clip_count += want.clipped;
          end_count  += want.period_end;
        end
      end
      if (in_valid_i && in_ready_o) begin
        pending_samples.push_back(next_sample(restart_i));
        tick_count++;
        restart_count += restart_i;
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("no progress after %0d cycles, %0d samples outstanding",
             cycle_count, pending_samples.size());
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers, all entered and left just after a falling edge
  // ---------------------------------------------------------------------------

  task automatic set_idling(input idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 46 : (mode == IDLE_BOTH) ? 29 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 46 : (mode == IDLE_BOTH) ? 29 : 0;
  endtask

  // one tick transaction; valid is only dropped when a gap is taken, so it
  // stays high across back-to-back ticks
  task automatic send_tick(input logic restart);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // stop sending and let every pending sample come out, plus pipeline slack
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_samples.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // single register write; the shadow copy follows, unused indexes are dropped
  task automatic write_reg(input logic [sswg_pkg::CfgIndexW-1:0] idx,
                           input logic [sswg_pkg::CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      sswg_pkg::REG_WAVE_KIND:    kind_reg = data[1:0];
      sswg_pkg::REG_DC_OFFSET:    dc_reg   = data;
      sswg_pkg::REG_AMPLITUDE:    amp_reg  = data;
      sswg_pkg::REG_SAMPLE_COUNT: cnt_reg  = data[sswg_pkg::SampleCountW-1:0];
      sswg_pkg::REG_PHASE_STEP:   step_reg = data;
      default: begin
      end
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // full register setup, only ever with the block idle
  task automatic program_wave(input logic [1:0] kind, input logic [15:0] dc,
                              input logic [15:0] amp,
                              input logic [sswg_pkg::SampleCountW-1:0] count,
                              input logic [15:0] step);
    wait_drained();
    write_reg(sswg_pkg::REG_WAVE_KIND, sswg_pkg::CfgDataW'(kind));
    write_reg(sswg_pkg::REG_DC_OFFSET, dc);
    write_reg(sswg_pkg::REG_AMPLITUDE, amp);
    write_reg(sswg_pkg::REG_SAMPLE_COUNT, sswg_pkg::CfgDataW'(count));
    write_reg(sswg_pkg::REG_PHASE_STEP, step);
    setup_count++;
  endtask

  // random setup: mostly moderate levels and short periods with the usual
  // step, now and then full-range values, odd counts and a stray write
  task automatic program_random_wave();
    logic [1:0]                        kind;
    logic [15:0]                       dc;
    logic [15:0]                       amp;
    logic [15:0]                       step;
    logic [sswg_pkg::SampleCountW-1:0] count;
    logic [sswg_pkg::CfgIndexW-1:0]    spare_idx;
    int unsigned                       pick;
    int unsigned                       eff;
    kind = 2'($urandom_range(3));
    dc   = ($urandom_range(99) < 60) ? 16'(int'($urandom_range(2048)) - 1024) : 16'($urandom);
    amp  = ($urandom_range(99) < 60) ? 16'(int'($urandom_range(4096)) - 2048) : 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 70) begin
      count = sswg_pkg::SampleCountW'($urandom_range(64, 2));
    end else if (pick < 85) begin
      count = sswg_pkg::SampleCountW'($urandom_range(MaxSamples, 65));
    end else begin
      count = sswg_pkg::SampleCountW'($urandom);
    end
    eff  = (count < 2) ? 2 : (count > MaxSamples) ? MaxSamples : count;
    step = ($urandom_range(99) < 80) ? 16'(65536 / eff) : 16'($urandom);
    program_wave(kind, dc, amp, count, step);
    if ($urandom_range(99) < 20) begin
      spare_idx = sswg_pkg::CfgIndexW'($urandom_range(RegTop, RegFirstUnused));
      write_reg(spare_idx, sswg_pkg::CfgDataW'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // register defaults and state straight out of reset
  task automatic test_reset_defaults();
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  // sine, square, dc and the unused code that acts as dc
  task automatic test_wave_kinds();
    logic [1:0] kinds [4];
    kinds = '{sswg_pkg::WAVE_SINE, sswg_pkg::WAVE_SQUARE, sswg_pkg::WAVE_DC, WaveUnused};
    foreach (kinds[i]) begin
      program_wave(kinds[i], 16'h0100, 16'h0200, 9'd4, 16'h4000);
      send_tick(1'b0);
    end
  endtask

  // level extremes pushing the result past both rails
  task automatic test_saturation();
    program_wave(sswg_pkg::WAVE_SQUARE, 16'h7fff, 16'h7fff, 9'd2, 16'h8000);
    send_tick(1'b1);
    send_tick(1'b0);
    program_wave(sswg_pkg::WAVE_SQUARE, 16'h8000, 16'h7fff, 9'd2, 16'h8000);
    send_tick(1'b1);
    send_tick(1'b0);
    // quarter phase hits the table end with the most negative amplitude
    program_wave(sswg_pkg::WAVE_SINE, 16'h8000, 16'h8000, 9'd4, 16'h4000);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // counts below two and above the maximum are pinned
  task automatic test_count_limits();
    program_wave(sswg_pkg::WAVE_SQUARE, 16'h0000, 16'h0100, 9'd0, 16'h8000);
    send_tick(1'b1);
    send_tick(1'b0);
    program_wave(sswg_pkg::WAVE_SQUARE, 16'h0000, 16'hff00, 9'd1, 16'h8000);
    send_tick(1'b1);
    send_tick(1'b0);
    program_wave(sswg_pkg::WAVE_SINE, 16'h0040, 16'h0100, 9'h1ff, 16'h0100);
    send_tick(1'b1);
  endtask

  // count lowered mid-period: the stale index ends the period and wraps
  task automatic test_index_past_end();
    program_wave(sswg_pkg::WAVE_SQUARE, 16'h0000, 16'h0080, 9'd8, 16'h2000);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
    program_wave(sswg_pkg::WAVE_SQUARE, 16'h0000, 16'h0080, 9'd2, 16'h8000);
    send_tick(1'b0);
  endtask

  // near-full step makes the accumulator wrap on every sample after the first
  task automatic test_phase_wrap();
    program_wave(sswg_pkg::WAVE_SINE, 16'h0000, 16'h7fff, 9'd256, 16'hffff);
    send_tick(1'b1);
    repeat (3) send_tick(1'b0);
  endtask

  // writes to unused indexes must leave the setup alone
  task automatic test_unused_registers();
    logic [sswg_pkg::CfgIndexW-1:0] idx;
    wait_drained();
    for (int i = RegFirstUnused; i <= RegTop; i++) begin
      idx = sswg_pkg::CfgIndexW'(i);
      write_reg(idx, sswg_pkg::CfgDataW'($urandom));
    end
    send_tick(1'b0);
    send_tick(1'b0);
  endtask

  // one long period reaching the last position, under mixed idling
  task automatic test_full_period();
    set_idling(IDLE_BOTH);
    program_wave(sswg_pkg::WAVE_SINE, 16'(int'($urandom_range(512)) - 256), 16'($urandom),
                 9'd256, 16'd256);
    send_tick(1'b1);
    repeat (FullPeriodTicks - 1) send_tick(1'b0);
  endtask

  // random setups in short bursts, cycling through the idling mixes; each
  // burst ends with the sender waiting for every sample to come back
  task automatic test_random_streams();
    int unsigned sent;
    int unsigned burst;
    int unsigned round;
    sent  = 0;
    round = 0;
    while (sent < RandomTicks) begin
      set_idling(idle_mode_e'(round % 4));
      program_random_wave();
      burst = $urandom_range(60, 20);
      repeat (burst) send_tick($urandom_range(99) < 4);
      sent += burst;
      round++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int k = 0; k <= RomDepth; k++) begin
      sine_rom[k] = rom_entry(k);
    end
    set_idling(IDLE_NONE);
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_wave_kinds();
    test_saturation();
    test_count_limits();
    test_index_past_end();
    test_phase_wrap();
    test_unused_registers();
    test_full_period();
    test_random_streams();
    wait_drained();

    $display("%0d ticks (%0d with restart) over %0d setups, %0d samples checked in %0d cycles",
             tick_count, restart_count, setup_count, checked_count, cycle_count);
    $display("%0d saturated samples, %0d period ends, %0d mismatches",
             clip_count, end_count, mismatch_count);
    if (mismatch_count == 0 && pending_samples.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/sswg_pkg.sv
rtl/sswg_sine_rom.sv
rtl/sswg_seq.sv
rtl/sswg_shape.sv
rtl/sine_square_waveform_generator.sv
dv/sine_square_waveform_generator_test.sv
